// File: design/cct_pkg.sv
`default_nettype none

package cct_pkg;

  // Default width of positions and run lengths
  localparam int unsigned PosBitsDef = 16;

  // Output field widths
  localparam int unsigned OutPosBits = 16;
  localparam int unsigned ClassBits  = 5;

  // Result buffer sizing
  localparam int unsigned MaxTok    = 3;
  localparam int unsigned BufDepth  = 4;
  localparam int unsigned BufIdxW   = $clog2(BufDepth);
  localparam int unsigned BufCntW   = $clog2(BufDepth + 1);

  // Token classes
  localparam logic [ClassBits-1:0] ClsLetters   = 5'd0;
  localparam logic [ClassBits-1:0] ClsDigits    = 5'd1;
  localparam logic [ClassBits-1:0] ClsBlanks    = 5'd2;
  localparam logic [ClassBits-1:0] ClsTabs      = 5'd3;
  localparam logic [ClassBits-1:0] ClsOthers    = 5'd4;
  localparam logic [ClassBits-1:0] ClsDot       = 5'd5;
  localparam logic [ClassBits-1:0] ClsComma     = 5'd6;
  localparam logic [ClassBits-1:0] ClsNewline   = 5'd7;
  localparam logic [ClassBits-1:0] ClsParenL    = 5'd8;
  localparam logic [ClassBits-1:0] ClsParenR    = 5'd9;
  localparam logic [ClassBits-1:0] ClsBraceL    = 5'd10;
  localparam logic [ClassBits-1:0] ClsBraceR    = 5'd11;
  localparam logic [ClassBits-1:0] ClsBracketL  = 5'd12;
  localparam logic [ClassBits-1:0] ClsBracketR  = 5'd13;
  localparam logic [ClassBits-1:0] ClsAngleL    = 5'd14;
  localparam logic [ClassBits-1:0] ClsAngleR    = 5'd15;
  localparam logic [ClassBits-1:0] ClsUnderscore = 5'd16;
  localparam logic [ClassBits-1:0] ClsBackslash = 5'd17;

  // Character codes
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChParenL    = 8'h28;
  localparam logic [7:0] ChParenR    = 8'h29;
  localparam logic [7:0] ChBraceL    = 8'h7B;
  localparam logic [7:0] ChBraceR    = 8'h7D;
  localparam logic [7:0] ChBracketL  = 8'h5B;
  localparam logic [7:0] ChBracketR  = 8'h5D;
  localparam logic [7:0] ChAngleL    = 8'h3C;
  localparam logic [7:0] ChAngleR    = 8'h3E;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChBackslash = 8'h5C;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [ClassBits-1:0]  token_class;
    logic [OutPosBits-1:0] token_offset;
    logic [OutPosBits-1:0] token_length;
    logic                  batch_last;
    logic                  text_last;
  } tok_t;

  // Byte to class; CR falls into others
  function automatic logic [ClassBits-1:0] classify(input logic [7:0] b);
    logic [ClassBits-1:0] c;
    c = ClsOthers;
    if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) begin
      c = ClsLetters;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      c = ClsDigits;
    end else begin
      unique case (b)
        ChSpace:      c = ClsBlanks;
        ChTab:        c = ClsTabs;
        ChDot:        c = ClsDot;
        ChComma:      c = ClsComma;
        ChLf:         c = ClsNewline;
        ChParenL:     c = ClsParenL;
        ChParenR:     c = ClsParenR;
        ChBraceL:     c = ClsBraceL;
        ChBraceR:     c = ClsBraceR;
        ChBracketL:   c = ClsBracketL;
        ChBracketR:   c = ClsBracketR;
        ChAngleL:     c = ClsAngleL;
        ChAngleR:     c = ClsAngleR;
        ChUnderscore: c = ClsUnderscore;
        ChBackslash:  c = ClsBackslash;
        default:      c = ClsOthers;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/char_class_run_tokenizer_core.sv
`default_nettype none

// Channel | Direction | Handshake                      | Payload
// in      | input     | in_valid_i / in_ready_o        | in_data_i  (in_t: text_byte, text_end)
// out     | output    | out_valid_o / out_ready_i      | out_data_o (tok_t)
//
// A text byte is classified and merged in the cycle it is accepted; its tokens
// (zero to three) land in a four-entry result buffer the same edge.
// Tokens leave the buffer one per cycle while out_ready_i is high.
// Input is taken whenever at most one token waits: one byte per cycle while each byte
// closes at most one token and the output side keeps up.
// Reset clears the open run, the pending CR, the byte position and the buffer.
module char_class_run_tokenizer_core
  import cct_pkg::*;
#(
  parameter int unsigned PosBits = PosBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output tok_t      out_data_o
);

  localparam int unsigned NumCand = 5;
  localparam int unsigned WideSel = (PosBits > OutPosBits) ? PosBits : OutPosBits;

  // Tokenizer state
  logic                 open_vld_q, open_vld_d;
  logic [ClassBits-1:0] open_cls_q, open_cls_d;
  logic [PosBits-1:0]   open_start_q, open_start_d;
  logic [PosBits-1:0]   open_len_q, open_len_d;
  logic                 cr_pend_q, cr_pend_d;
  logic [PosBits-1:0]   cr_pos_q, cr_pos_d;
  logic [PosBits-1:0]   byte_pos_q, byte_pos_d;

  // Result buffer
  tok_t                 buf_q [BufDepth];
  logic [BufIdxW-1:0]   wptr_q, wptr_d;
  logic [BufIdxW-1:0]   rptr_q, rptr_d;
  logic [BufCntW-1:0]   cnt_q, cnt_d;

  logic in_acc;
  logic out_acc;
  logic is_cr;
  logic is_lf;
  logic end_b;

  // Phase A: resolve a pending CR
  logic                 a_en;
  logic [ClassBits-1:0] a_cls;
  logic [PosBits-1:0]   a_len;
  logic                 a_vld;
  logic [ClassBits-1:0] a_ocls;
  logic [PosBits-1:0]   a_start;
  logic [PosBits-1:0]   a_olen;
  logic                 a_fv, a_sv;
  tok_t                 a_ft, a_st;

  // Phase B: the byte itself
  logic                 b_en;
  logic                 b_vld;
  logic [ClassBits-1:0] b_ocls;
  logic [PosBits-1:0]   b_start;
  logic [PosBits-1:0]   b_olen;
  logic                 b_fv, b_sv;
  tok_t                 b_ft, b_st;

  // End of text flush
  tok_t end_tok;
  logic [WideSel-1:0] end_start_w;
  logic [WideSel-1:0] end_len_w;

  tok_t               cand [NumCand];
  logic [NumCand-1:0] cand_v;
  tok_t               slot [MaxTok];
  logic [1:0]         n_tok;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  assign is_cr = (in_data_i.text_byte == ChCr);
  assign is_lf = (in_data_i.text_byte == ChLf);
  assign end_b = in_data_i.text_end;

  // CR LF becomes a newline of length two, else the CR is an other byte
  assign a_en  = cr_pend_q;
  assign a_cls = is_lf ? ClsNewline : ClsOthers;
  assign a_len = is_lf ? PosBits'(2) : PosBits'(1);

  cct_merge #(.PosBits(PosBits)) u_merge_a (
    .en_i        (a_en),
    .cls_i       (a_cls),
    .pos_i       (cr_pos_q),
    .len_i       (a_len),
    .open_vld_i  (open_vld_q),
    .open_cls_i  (open_cls_q),
    .open_start_i(open_start_q),
    .open_len_i  (open_len_q),
    .open_vld_o  (a_vld),
    .open_cls_o  (a_ocls),
    .open_start_o(a_start),
    .open_len_o  (a_olen),
    .flush_vld_o (a_fv),
    .flush_tok_o (a_ft),
    .solo_vld_o  (a_sv),
    .solo_tok_o  (a_st)
  );

  // Byte is skipped when it completed a CR LF or is a CR held for the next byte
  assign b_en = !(cr_pend_q && is_lf) && !(is_cr && !end_b);

  cct_merge #(.PosBits(PosBits)) u_merge_b (
    .en_i        (b_en),
    .cls_i       (classify(in_data_i.text_byte)),
    .pos_i       (byte_pos_q),
    .len_i       (PosBits'(1)),
    .open_vld_i  (a_vld),
    .open_cls_i  (a_ocls),
    .open_start_i(a_start),
    .open_len_i  (a_olen),
    .open_vld_o  (b_vld),
    .open_cls_o  (b_ocls),
    .open_start_o(b_start),
    .open_len_o  (b_olen),
    .flush_vld_o (b_fv),
    .flush_tok_o (b_ft),
    .solo_vld_o  (b_sv),
    .solo_tok_o  (b_st)
  );

  // Open run closed at end of text
  assign end_start_w = WideSel'(b_start);
  assign end_len_w   = WideSel'(b_olen);

  always_comb begin
    end_tok              = '0;
    end_tok.token_class  = b_ocls;
    end_tok.token_offset = end_start_w[OutPosBits-1:0];
    end_tok.token_length = end_len_w[OutPosBits-1:0];
  end

  // Candidates in emission order
  always_comb begin
    cand[0] = a_ft;
    cand[1] = a_st;
    cand[2] = b_ft;
    cand[3] = b_st;
    cand[4] = end_tok;
    cand_v  = {end_b && b_vld, b_sv, b_fv, a_sv, a_fv};
  end

  // Pack valid candidates into slots and tag the last one
  always_comb begin
    n_tok = 2'd0;
    for (int j = 0; j < MaxTok; j++) begin
      slot[j] = '0;
    end
    for (int i = 0; i < NumCand; i++) begin
      if (cand_v[i] && (n_tok < 2'(MaxTok))) begin
        slot[n_tok] = cand[i];
        n_tok       = n_tok + 2'd1;
      end
    end
    for (int j = 0; j < MaxTok; j++) begin
      if ((n_tok != 2'd0) && (2'(j) == n_tok - 2'd1)) begin
        slot[j].batch_last = 1'b1;
        slot[j].text_last  = end_b;
      end
    end
  end

  // Next tokenizer state
  always_comb begin
    open_vld_d   = open_vld_q;
    open_cls_d   = open_cls_q;
    open_start_d = open_start_q;
    open_len_d   = open_len_q;
    cr_pend_d    = cr_pend_q;
    cr_pos_d     = cr_pos_q;
    byte_pos_d   = byte_pos_q;
    if (in_acc) begin
      if (end_b) begin
        open_vld_d   = 1'b0;
        open_cls_d   = '0;
        open_start_d = '0;
        open_len_d   = '0;
        cr_pend_d    = 1'b0;
        cr_pos_d     = '0;
        byte_pos_d   = '0;
      end else begin
        open_vld_d   = b_vld;
        open_cls_d   = b_ocls;
        open_start_d = b_start;
        open_len_d   = b_olen;
        cr_pend_d    = is_cr;
        cr_pos_d     = is_cr ? byte_pos_q : cr_pos_q;
        byte_pos_d   = byte_pos_q + PosBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_vld_q   <= 1'b0;
      open_cls_q   <= '0;
      open_start_q <= '0;
      open_len_q   <= '0;
      cr_pend_q    <= 1'b0;
      cr_pos_q     <= '0;
      byte_pos_q   <= '0;
    end else begin
      open_vld_q   <= open_vld_d;
      open_cls_q   <= open_cls_d;
      open_start_q <= open_start_d;
      open_len_q   <= open_len_d;
      cr_pend_q    <= cr_pend_d;
      cr_pos_q     <= cr_pos_d;
      byte_pos_q   <= byte_pos_d;
    end
  end

  // Buffer pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      wptr_d = wptr_q + BufIdxW'(n_tok);
      cnt_d  = cnt_d + BufCntW'(n_tok);
    end
    if (out_acc) begin
      rptr_d = rptr_q + BufIdxW'(1);
      cnt_d  = cnt_d - BufCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Buffer entries
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int j = 0; j < MaxTok; j++) begin
        if (2'(j) < n_tok) begin
          buf_q[wptr_q + BufIdxW'(j)] <= slot[j];
        end
      end
    end
  end

  // Room for a full batch of tokens
  assign in_ready_o  = (cnt_q <= BufCntW'(BufDepth - MaxTok));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rptr_q];

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BufCntW'(BufDepth))
    else $error("result buffer overfilled");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && out_acc) |=> (cnt_q == $past(cnt_q) - BufCntW'(1)))
    else $error("fill count wrong after pop");

  a_text_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.text_end) |=>
      (!open_vld_q && !cr_pend_q && (byte_pos_q == '0)))
    else $error("state not cleared at end of text");

  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.text_last) |-> out_data_o.batch_last)
    else $error("text_last without batch_last");

  a_cr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.text_byte == ChCr) && !in_data_i.text_end) |=> cr_pend_q)
    else $error("CR not held");

endmodule

`default_nettype wire

// File: design/cct_merge.sv
`default_nettype none

// Adds one classified byte to the open run token.
// Run classes extend or restart the run; other classes close it and make a token.
module cct_merge
  import cct_pkg::*;
#(
  parameter int unsigned PosBits = PosBitsDef
) (
  input  wire logic                 en_i,
  input  wire logic [ClassBits-1:0] cls_i,
  input  wire logic [PosBits-1:0]   pos_i,
  input  wire logic [PosBits-1:0]   len_i,
  input  wire logic                 open_vld_i,
  input  wire logic [ClassBits-1:0] open_cls_i,
  input  wire logic [PosBits-1:0]   open_start_i,
  input  wire logic [PosBits-1:0]   open_len_i,
  output logic                      open_vld_o,
  output logic [ClassBits-1:0]      open_cls_o,
  output logic [PosBits-1:0]        open_start_o,
  output logic [PosBits-1:0]        open_len_o,
  output logic                      flush_vld_o,
  output tok_t                      flush_tok_o,
  output logic                      solo_vld_o,
  output tok_t                      solo_tok_o
);

  localparam int unsigned WideBits = (PosBits > OutPosBits) ? PosBits : OutPosBits;

  logic                is_run;
  logic                extend;
  logic [WideBits-1:0] start_w;
  logic [WideBits-1:0] len_w;
  logic [WideBits-1:0] pos_w;
  logic [WideBits-1:0] solo_len_w;

  assign is_run = (cls_i <= ClsOthers);
  // A run at full length is split
  assign extend = open_vld_i && (open_cls_i == cls_i) && (open_len_i != '1);

  // Positions reported in the low output bits
  assign start_w    = WideBits'(open_start_i);
  assign len_w      = WideBits'(open_len_i);
  assign pos_w      = WideBits'(pos_i);
  assign solo_len_w = WideBits'(len_i);

  always_comb begin
    flush_tok_o              = '0;
    flush_tok_o.token_class  = open_cls_i;
    flush_tok_o.token_offset = start_w[OutPosBits-1:0];
    flush_tok_o.token_length = len_w[OutPosBits-1:0];

    solo_tok_o              = '0;
    solo_tok_o.token_class  = cls_i;
    solo_tok_o.token_offset = pos_w[OutPosBits-1:0];
    solo_tok_o.token_length = solo_len_w[OutPosBits-1:0];
  end

  // Merge decision
  always_comb begin
    open_vld_o   = open_vld_i;
    open_cls_o   = open_cls_i;
    open_start_o = open_start_i;
    open_len_o   = open_len_i;
    flush_vld_o  = 1'b0;
    solo_vld_o   = 1'b0;
    if (en_i) begin
      if (is_run && extend) begin
        open_len_o = open_len_i + PosBits'(1);
      end else if (is_run) begin
        flush_vld_o  = open_vld_i;
        open_vld_o   = 1'b1;
        open_cls_o   = cls_i;
        open_start_o = pos_i;
        open_len_o   = PosBits'(1);
      end else begin
        flush_vld_o = open_vld_i;
        open_vld_o  = 1'b0;
        solo_vld_o  = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
